// ===== rtl/rrfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Radar report frame parser package
// Shared constants, frame layout offsets, status codes and channel payloads.
// ----------------------------------------------------------------------------
package rrfp_pkg;

  localparam int FRAME_BYTES_DEF = 128;
  localparam int GATE_COUNT_DEF  = 9;

  localparam int HDR_LEN  = 4;
  localparam int HIST_LEN = 5;

  localparam logic [7:0] FTR_B0    = 8'hF8;
  localparam logic [7:0] FTR_B1    = 8'hF7;
  localparam logic [7:0] FTR_B2    = 8'hF6;
  localparam logic [7:0] FTR_B3    = 8'hF5;
  localparam logic [7:0] INNER_HDR = 8'hAA;
  localparam logic [7:0] TAIL_B0   = 8'h55;
  localparam logic [7:0] TAIL_B1   = 8'h00;
  localparam logic [7:0] TYPE_ENG  = 8'h01;
  localparam logic [7:0] TYPE_BAS  = 8'h02;

  // byte offsets within the frame
  localparam int IDX_LEN_LO  = 4;
  localparam int IDX_LEN_HI  = 5;
  localparam int IDX_TYPE    = 6;
  localparam int IDX_AA      = 7;
  localparam int IDX_STATE   = 8;
  localparam int IDX_MDIST_L = 9;
  localparam int IDX_MDIST_H = 10;
  localparam int IDX_MENERGY = 11;
  localparam int IDX_SDIST_L = 12;
  localparam int IDX_SDIST_H = 13;
  localparam int IDX_SENERGY = 14;
  localparam int IDX_DDIST_L = 15;
  localparam int IDX_DDIST_H = 16;
  localparam int MIN_END_IDX = 11;
  localparam int MIN_PAY_LEN = 13;

  localparam logic [2:0] ST_VALID       = 3'd0;
  localparam logic [2:0] ST_LEN_BIG     = 3'd1;
  localparam logic [2:0] ST_BAD_FOOTER  = 3'd2;
  localparam logic [2:0] ST_BAD_PAYLOAD = 3'd3;
  localparam logic [2:0] ST_BAD_TAIL    = 3'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  tgt_state;
    logic        state_changed;
    logic [7:0]  previous_state;
    logic [15:0] moving_distance;
    logic [7:0]  moving_power;
    logic [15:0] still_distance;
    logic [7:0]  still_power;
    logic [15:0] detect_distance;
    logic        engineering;
    logic [7:0]  light_level;
    logic [7:0]  out_pin;
  } report_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } byte_stage_t;

  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'hF4;
      2'd1:    b = 8'hF3;
      2'd2:    b = 8'hF2;
      default: b = 8'hF1;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/rrfp_stream_if.sv =====
// ----------------------------------------------------------------------------
// Radar report frame parser stream interface
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface rrfp_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rrfp_input_stage.sv =====
// ----------------------------------------------------------------------------
// Radar report frame parser input stage
// Registers each received byte ahead of the frame decoder.
// ----------------------------------------------------------------------------
module rrfp_input_stage (
  input  logic                 clk,
  input  logic                 rst,
  rrfp_stream_if.sink          rx,
  input  logic                 take,
  output rrfp_pkg::byte_stage_t stage
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign rx.ready      = !valid_q || take;
  assign stage.valid   = valid_q;
  assign stage.rx_byte = byte_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (rx.ready) begin
      valid_q <= rx.valid;
    end
    if (rx.ready) begin
      byte_q <= rx.data.rx_byte;
    end
  end

endmodule

// ===== rtl/rrfp_parser.sv =====
// ----------------------------------------------------------------------------
// Radar report frame parser decoder
// Tracks frame position, captures fields by offset and issues verdicts.
// ----------------------------------------------------------------------------
module rrfp_parser #(
  parameter int FRAME_BYTES = rrfp_pkg::FRAME_BYTES_DEF,
  parameter int GATE_COUNT  = rrfp_pkg::GATE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rrfp_pkg::byte_stage_t stage,
  input  logic                  take,
  output logic                  res_valid,
  output rrfp_pkg::report_t     res
);

  localparam int PW        = $clog2(FRAME_BYTES + 1);
  localparam int LIGHT_IDX = 19 + 2 * GATE_COUNT;
  localparam int PIN_IDX   = 20 + 2 * GATE_COUNT;
  localparam int ENG_LEN   = 17 + 2 * GATE_COUNT;
  localparam int MAX_LEN   = FRAME_BYTES - 10;

  logic [PW-1:0] pos_q;
  logic [PW-1:0] pos_next;
  logic [PW-1:0] len_q;
  logic [PW-1:0] end_idx_q;
  logic [7:0]    len_lo_q;
  logic [7:0]    hist_q [rrfp_pkg::HIST_LEN];
  logic [7:0]    type_q;
  logic [7:0]    aa_q;
  logic [7:0]    state_q;
  logic [15:0]   mdist_q;
  logic [7:0]    menergy_q;
  logic [15:0]   sdist_q;
  logic [7:0]    senergy_q;
  logic [15:0]   ddist_q;
  logic [7:0]    light_q;
  logic [7:0]    pin_q;
  logic [7:0]    last_state_q;

  logic          fire;
  logic [7:0]    ch;
  logic [15:0]   pos16;
  logic [15:0]   len16;
  logic [15:0]   len_full;
  logic          hdr_miss;
  logic          len_big;
  logic          at_len_hi;
  logic          at_end;
  logic [PW-1:0] end_idx_new;
  logic [7:0]    f0, f1, f2, f3;
  logic          ftr_match;
  logic          payload_ok;
  logic          tail_ok;
  logic          verdict;
  logic [2:0]    status;
  logic          eng;

  assign fire     = stage.valid && take;
  assign ch       = stage.rx_byte;
  assign pos16    = 16'(pos_q);
  assign len16    = 16'(len_q);
  assign len_full = {ch, len_lo_q};
  assign hdr_miss = (pos_q < PW'(rrfp_pkg::HDR_LEN)) && (ch != rrfp_pkg::hdr_byte(pos_q[1:0]));
  assign at_len_hi = pos16 == 16'(rrfp_pkg::IDX_LEN_HI);
  assign len_big   = len_full > 16'(MAX_LEN);
  assign end_idx_new = (len_full < 16'(2)) ? PW'(rrfp_pkg::MIN_END_IDX)
                                           : PW'(len_full + 16'd9);
  assign at_end = (pos16 > 16'(rrfp_pkg::IDX_LEN_HI)) && (pos_q == end_idx_q);

  always_comb begin
    if (len16 == 16'd0) begin
      f0 = hist_q[4]; f1 = hist_q[3]; f2 = hist_q[2]; f3 = hist_q[1];
    end else if (len16 == 16'd1) begin
      f0 = hist_q[3]; f1 = hist_q[2]; f2 = hist_q[1]; f3 = hist_q[0];
    end else begin
      f0 = hist_q[2]; f1 = hist_q[1]; f2 = hist_q[0]; f3 = ch;
    end
  end

  assign ftr_match  = (f0 == rrfp_pkg::FTR_B0) && (f1 == rrfp_pkg::FTR_B1) &&
                      (f2 == rrfp_pkg::FTR_B2) && (f3 == rrfp_pkg::FTR_B3);
  assign payload_ok = (len16 >= 16'(rrfp_pkg::MIN_PAY_LEN)) &&
                      ((type_q == rrfp_pkg::TYPE_ENG) || (type_q == rrfp_pkg::TYPE_BAS)) &&
                      (aa_q == rrfp_pkg::INNER_HDR);
  assign tail_ok    = (hist_q[4] == rrfp_pkg::TAIL_B0) && (hist_q[3] == rrfp_pkg::TAIL_B1);
  assign eng        = (type_q == rrfp_pkg::TYPE_ENG) && (len16 >= 16'(ENG_LEN));

  always_comb begin
    pos_next = pos_q + PW'(1);
    verdict  = 1'b0;
    status   = rrfp_pkg::ST_VALID;
    if (hdr_miss) begin
      pos_next = '0;
    end else if (at_len_hi && len_big) begin
      pos_next = '0;
      verdict  = 1'b1;
      status   = rrfp_pkg::ST_LEN_BIG;
    end else if (at_end) begin
      pos_next = '0;
      verdict  = 1'b1;
      if (!ftr_match) begin
        status = rrfp_pkg::ST_BAD_FOOTER;
      end else if (!payload_ok) begin
        status = rrfp_pkg::ST_BAD_PAYLOAD;
      end else if (!tail_ok) begin
        status = rrfp_pkg::ST_BAD_TAIL;
      end
    end
  end

  assign res_valid = fire && verdict;

  always_comb begin
    res                = '0;
    res.status         = status;
    res.previous_state = last_state_q;
    if (status == rrfp_pkg::ST_VALID) begin
      res.tgt_state       = state_q;
      res.state_changed   = state_q != last_state_q;
      res.moving_distance = mdist_q;
      res.moving_power    = menergy_q;
      res.still_distance  = sdist_q;
      res.still_power     = senergy_q;
      res.detect_distance = ddist_q;
      if (eng) begin
        res.engineering = 1'b1;
        res.light_level = light_q;
        res.out_pin     = pin_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_q        <= '0;
      last_state_q <= '0;
    end else if (fire) begin
      pos_q <= pos_next;
      if (verdict && (status == rrfp_pkg::ST_VALID)) begin
        last_state_q <= state_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hist_q[0] <= ch;
      for (int i = 1; i < rrfp_pkg::HIST_LEN; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
      if (pos16 == 16'(rrfp_pkg::IDX_LEN_LO)) len_lo_q <= ch;
      if (at_len_hi) begin
        len_q     <= PW'(len_full);
        end_idx_q <= end_idx_new;
      end
      if (pos16 == 16'(rrfp_pkg::IDX_TYPE))    type_q         <= ch;
      if (pos16 == 16'(rrfp_pkg::IDX_AA))      aa_q           <= ch;
      if (pos16 == 16'(rrfp_pkg::IDX_STATE))   state_q        <= ch;
      if (pos16 == 16'(rrfp_pkg::IDX_MDIST_L)) mdist_q[7:0]   <= ch;
      if (pos16 == 16'(rrfp_pkg::IDX_MDIST_H)) mdist_q[15:8]  <= ch;
      if (pos16 == 16'(rrfp_pkg::IDX_MENERGY)) menergy_q      <= ch;
      if (pos16 == 16'(rrfp_pkg::IDX_SDIST_L)) sdist_q[7:0]   <= ch;
      if (pos16 == 16'(rrfp_pkg::IDX_SDIST_H)) sdist_q[15:8]  <= ch;
      if (pos16 == 16'(rrfp_pkg::IDX_SENERGY)) senergy_q      <= ch;
      if (pos16 == 16'(rrfp_pkg::IDX_DDIST_L)) ddist_q[7:0]   <= ch;
      if (pos16 == 16'(rrfp_pkg::IDX_DDIST_H)) ddist_q[15:8]  <= ch;
      if (pos16 == 16'(LIGHT_IDX))             light_q        <= ch;
      if (pos16 == 16'(PIN_IDX))               pin_q          <= ch;
    end
  end

endmodule

// ===== rtl/rrfp_output_stage.sv =====
// ----------------------------------------------------------------------------
// Radar report frame parser output stage
// Holds one report until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module rrfp_output_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  rrfp_pkg::report_t res,
  output logic              open,
  rrfp_stream_if.source     report
);

  logic              valid_q;
  rrfp_pkg::report_t data_q;

  assign open         = !valid_q || report.ready;
  assign report.valid = valid_q;
  assign report.data  = data_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (open) begin
      valid_q <= res_valid;
    end
    if (open) begin
      data_q <= res;
    end
  end

endmodule

// ===== rtl/radar_report_frame_parser_unit.sv =====
// Path: a frame's last byte is decoded from the input register into the report register.
// Throughput: one byte per cycle, set by the single decode stage between the
// input register and the report register; the input stalls only while a report waits.
// Reset: rst synchronous, active high; clears the frame position, the last valid
// target state and both stage valid flags. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Radar report frame parser unit
// Top level: input register, frame decoder and report register.
// ----------------------------------------------------------------------------
module radar_report_frame_parser_unit #(
  parameter int FRAME_BYTES = rrfp_pkg::FRAME_BYTES_DEF,
  parameter int GATE_COUNT  = rrfp_pkg::GATE_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  rrfp_stream_if.sink   rx,
  rrfp_stream_if.source report
);

  rrfp_pkg::byte_stage_t stage;
  rrfp_pkg::report_t     res;
  logic                  res_valid;
  logic                  open;

  rrfp_input_stage u_input (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .take  (open),
    .stage (stage)
  );

  rrfp_parser #(
    .FRAME_BYTES (FRAME_BYTES),
    .GATE_COUNT  (GATE_COUNT)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .take      (open),
    .res_valid (res_valid),
    .res       (res)
  );

  rrfp_output_stage u_output (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .open      (open),
    .report    (report)
  );

endmodule

// ===== verif/radar_report_frame_parser_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radar report frame parser unit testbench
// Streams directed and random report frames (clean, truncated and corrupted)
// into the byte channel and checks every report, field by field, against an
// in-bench frame decoder. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module radar_report_frame_parser_unit_tb;
  import rrfp_pkg::*;

  localparam int          STORE_BYTES  = FRAME_BYTES_DEF;
  localparam int          MAX_LEN      = STORE_BYTES - 10;
  localparam int          ENG_LEN      = 17 + 2 * GATE_COUNT_DEF;
  localparam logic [31:0] SYNC_WORD    = 32'hF4F3F2F1;
  localparam logic [31:0] FOOTER_WORD  = {FTR_B0, FTR_B1, FTR_B2, FTR_B3};
  localparam int          RANDOM_BYTES = 1000;
  localparam int          STALL_LIMIT  = 4000;

  typedef enum int {FLAW_NONE, FLAW_FOOTER, FLAW_INNER_HDR, FLAW_TAIL} flaw_t;

  logic clk;
  logic rst;

  rrfp_stream_if #(.payload_t(rx_item_t)) rx_ch ();
  rrfp_stream_if #(.payload_t(report_t))  report_ch ();

  radar_report_frame_parser_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .report (report_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  logic [7:0]  pending_bytes [$];
  report_t     expected_reports [$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_in = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          hold_cycles = 0;
  logic        hold_done = 1'b0;
  logic        calm;

  // frame decoder state
  logic [7:0]  frame_bytes [STORE_BYTES];
  int unsigned frame_pos = 0;
  logic [7:0]  last_state = 8'h00;

  assign calm = (bytes_in >= 1000) && (bytes_in < 1300);

  function automatic logic [7:0] stored(input int unsigned idx);
    return (idx < STORE_BYTES) ? frame_bytes[idx] : 8'h00;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    report_t     r;
    logic        done;
    int unsigned len;
    r = '0;
    done = 1'b0;
    if (frame_pos < HDR_LEN && b != SYNC_WORD[31 - 8 * frame_pos -: 8]) begin
      frame_pos = 0;
    end else if (frame_pos >= STORE_BYTES) begin
      done = 1'b1;
      r.status = ST_LEN_BIG;
    end else begin
      frame_bytes[frame_pos] = b;
      frame_pos++;
      len = {stored(IDX_LEN_HI), stored(IDX_LEN_LO)};
      if (frame_pos == 6 && len > MAX_LEN) begin
        done = 1'b1;
        r.status = ST_LEN_BIG;
      end else if (frame_pos >= 12 && frame_pos >= 10 + len) begin
        done = 1'b1;
        if ({stored(6 + len), stored(7 + len), stored(8 + len), stored(9 + len)}
            != FOOTER_WORD) begin
          r.status = ST_BAD_FOOTER;
        end else if (len < MIN_PAY_LEN ||
                     (stored(IDX_TYPE) != TYPE_ENG && stored(IDX_TYPE) != TYPE_BAS) ||
                     stored(IDX_AA) != INNER_HDR) begin
          r.status = ST_BAD_PAYLOAD;
        end else if (stored(IDX_TYPE + len - 2) != TAIL_B0 ||
                     stored(IDX_TYPE + len - 1) != TAIL_B1) begin
          r.status = ST_BAD_TAIL;
        end else begin
          r.status          = ST_VALID;
          r.tgt_state       = stored(IDX_STATE);
          r.state_changed   = (stored(IDX_STATE) != last_state);
          r.moving_distance = {stored(IDX_MDIST_H), stored(IDX_MDIST_L)};
          r.moving_power    = stored(IDX_MENERGY);
          r.still_distance  = {stored(IDX_SDIST_H), stored(IDX_SDIST_L)};
          r.still_power     = stored(IDX_SENERGY);
          r.detect_distance = {stored(IDX_DDIST_H), stored(IDX_DDIST_L)};
          if (stored(IDX_TYPE) == TYPE_ENG && len >= ENG_LEN) begin
            r.engineering = 1'b1;
            r.light_level = stored(IDX_TYPE + 13 + 2 * GATE_COUNT_DEF);
            r.out_pin     = stored(IDX_TYPE + 14 + 2 * GATE_COUNT_DEF);
          end
        end
      end else if (frame_pos >= STORE_BYTES) begin
        done = 1'b1;
        r.status = ST_LEN_BIG;
      end
    end
    if (done) begin
      r.previous_state = last_state;
      if (r.status == ST_VALID) begin
        last_state = r.tgt_state;
      end
      frame_pos = 0;
      expected_reports.push_back(r);
    end
  endtask

  task automatic check_field(input string label, input logic [15:0] exp_val,
                             input logic [15:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s expected %0h actual %0h", $time, label, exp_val, got_val);
      mismatches++;
    end
  endtask

  task automatic compare_report(input report_t exp_r, input report_t got_r);
    check_field("status", exp_r.status, got_r.status);
    check_field("tgt_state", exp_r.tgt_state, got_r.tgt_state);
    check_field("state_changed", exp_r.state_changed, got_r.state_changed);
    check_field("previous_state", exp_r.previous_state, got_r.previous_state);
    check_field("moving_distance", exp_r.moving_distance, got_r.moving_distance);
    check_field("moving_power", exp_r.moving_power, got_r.moving_power);
    check_field("still_distance", exp_r.still_distance, got_r.still_distance);
    check_field("still_power", exp_r.still_power, got_r.still_power);
    check_field("detect_distance", exp_r.detect_distance, got_r.detect_distance);
    check_field("engineering", exp_r.engineering, got_r.engineering);
    check_field("light_level", exp_r.light_level, got_r.light_level);
    check_field("out_pin", exp_r.out_pin, got_r.out_pin);
  endtask

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_frame(input int unsigned len, input logic [7:0] ptype,
                             input logic [7:0] tstate, input flaw_t flaw, input int fill);
    logic [7:0]  body [$];
    logic [7:0]  b;
    logic [7:0]  flip;
    int unsigned bad_i;
    flip  = 8'($urandom_range(1, 255));
    bad_i = $urandom_range(0, 3);
    for (int i = 0; i < HDR_LEN; i++) push_byte(SYNC_WORD[31 - 8 * i -: 8]);
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    if (len > MAX_LEN) return;
    for (int i = 0; i < len; i++) body.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    if (len > 0) body[0] = ptype;
    if (len > 1) body[1] = INNER_HDR;
    if (len > 2) body[2] = tstate;
    if (len > 4) begin
      body[len - 2] = TAIL_B0;
      body[len - 1] = TAIL_B1;
    end
    if (flaw == FLAW_INNER_HDR && len > 1) body[1] = body[1] ^ flip;
    if (flaw == FLAW_TAIL && len > 4) body[len - 1 - bad_i % 2] = body[len - 1 - bad_i % 2] ^ flip;
    foreach (body[i]) push_byte(body[i]);
    for (int i = 0; i < 4; i++) begin
      b = FOOTER_WORD[31 - 8 * i -: 8];
      if (flaw == FLAW_FOOTER && i == bad_i) b = b ^ flip;
      push_byte(b);
    end
    for (int i = 10 + len; i < 12; i++) push_byte(8'($urandom));
  endtask

  // partial header, then a stray byte that breaks it
  task automatic queue_broken_header(input int depth, input logic [7:0] stray);
    for (int i = 0; i < depth; i++) push_byte(SYNC_WORD[31 - 8 * i -: 8]);
    push_byte(stray);
  endtask

  task automatic queue_noise(input int count);
    for (int i = 0; i < count; i++) push_byte(8'($urandom));
    push_byte(8'h00);
  endtask

  task automatic queue_random_frame();
    int unsigned pick;
    int unsigned len;
    int          depth;
    logic [7:0]  tstate;
    logic [7:0]  ptype;
    pick   = $urandom_range(0, 99);
    len    = ($urandom_range(0, 9) == 0) ? $urandom_range(MIN_PAY_LEN, MAX_LEN)
                                         : $urandom_range(MIN_PAY_LEN, 40);
    tstate = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
    ptype  = ($urandom_range(0, 1) != 0) ? TYPE_ENG : TYPE_BAS;
    depth  = $urandom_range(1, 3);
    if ($urandom_range(0, 9) == 0) queue_noise($urandom_range(1, 6));
    if (pick < 30) begin
      queue_frame(len, TYPE_BAS, tstate, FLAW_NONE, -1);
    end else if (pick < 50) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(ENG_LEN, MAX_LEN)
                                        : $urandom_range(ENG_LEN, 60);
      queue_frame(len, TYPE_ENG, tstate, FLAW_NONE, -1);
    end else if (pick < 55) begin
      queue_frame($urandom_range(MIN_PAY_LEN, ENG_LEN - 1), TYPE_ENG, tstate, FLAW_NONE, -1);
    end else if (pick < 62) begin
      queue_frame($urandom_range(MAX_LEN + 1, 65535), ptype, tstate, FLAW_NONE, -1);
    end else if (pick < 68) begin
      queue_frame($urandom_range(0, MIN_PAY_LEN - 1), ptype, tstate, FLAW_NONE, -1);
    end else if (pick < 74) begin
      ptype = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(3, 255));
      queue_frame(len, ptype, tstate, FLAW_NONE, -1);
    end else if (pick < 80) begin
      queue_frame(len, ptype, tstate, FLAW_INNER_HDR, -1);
    end else if (pick < 86) begin
      queue_frame(len, ptype, tstate, FLAW_TAIL, -1);
    end else if (pick < 92) begin
      queue_frame(len, ptype, tstate, FLAW_FOOTER, -1);
    end else begin
      queue_broken_header(depth, SYNC_WORD[31 - 8 * depth -: 8] ^ 8'($urandom_range(1, 255)));
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || rx_ch.valid || expected_reports.size() != 0);
  endtask

  // byte sender
  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else if (!rx_ch.valid || rx_ch.ready) begin
      if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 17)) begin
        rx_ch.valid <= 1'b1;
        rx_ch.data  <= pending_bytes.pop_front();
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // report receiver; one long hold-off once traffic is under way
  always @(posedge clk) begin
    if (rst) begin
      report_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      report_ch.ready <= 1'b0;
      hold_cycles     <= hold_cycles - 1;
    end else if (!hold_done && bytes_in >= 600) begin
      report_ch.ready <= 1'b0;
      hold_cycles     <= 400;
      hold_done       <= 1'b1;
    end else begin
      report_ch.ready <= calm || ($urandom_range(0, 99) >= 17);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rx_ch.valid && rx_ch.ready) begin
        decode_byte(rx_ch.data.rx_byte);
        bytes_in <= bytes_in + 1;
      end
      if (report_ch.valid && report_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: report with none expected, actual status %0h", $time,
                   report_ch.data.status);
          mismatches++;
        end else begin
          compare_report(expected_reports.pop_front(), report_ch.data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (report_ch.valid && report_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned random_start;
    rst             = 1'b1;
    rx_ch.valid     = 1'b0;
    rx_ch.data      = '0;
    report_ch.ready = 1'b0;

    queue_frame(MIN_PAY_LEN, TYPE_BAS, 8'h00, FLAW_NONE, 0);
    queue_frame(MAX_LEN, TYPE_ENG, 8'hFF, FLAW_NONE, 8'hFF);
    queue_frame(ENG_LEN, TYPE_ENG, 8'h01, FLAW_NONE, -1);
    queue_frame(ENG_LEN - 1, TYPE_ENG, 8'h01, FLAW_NONE, -1);
    queue_broken_header(2, SYNC_WORD[31 -: 8]);
    queue_frame(MIN_PAY_LEN, TYPE_BAS, 8'h02, FLAW_NONE, -1);
    queue_frame(MAX_LEN + 1, TYPE_BAS, 8'h00, FLAW_NONE, -1);
    queue_frame(16'hFFFF, TYPE_ENG, 8'h00, FLAW_NONE, -1);
    queue_frame(0, TYPE_BAS, 8'h00, FLAW_NONE, -1);
    queue_frame(1, TYPE_ENG, 8'h00, FLAW_NONE, -1);
    queue_frame(MIN_PAY_LEN - 1, TYPE_BAS, 8'h00, FLAW_NONE, -1);
    queue_frame(MIN_PAY_LEN, TYPE_BAS, 8'h03, FLAW_FOOTER, -1);
    queue_frame(MIN_PAY_LEN, 8'h00, 8'h03, FLAW_NONE, -1);
    queue_frame(MIN_PAY_LEN, TYPE_ENG, 8'h03, FLAW_INNER_HDR, -1);
    queue_frame(MIN_PAY_LEN, TYPE_BAS, 8'h03, FLAW_TAIL, -1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    wait_drained();
    random_start = bytes_queued;
    while (bytes_queued < random_start + RANDOM_BYTES) queue_random_frame();

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
